>>> rtl/cvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvs_pkg
// Types and constants shared by the command validation and supervision block.
// ----------------------------------------------------------------------------
package cvs_pkg;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_TIMEOUT   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_CHARGE    = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DISCHARGE = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAL_SUPPORTED = 8'd3;

   localparam logic CMD_RECEIVE = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

   localparam logic [2:0] MODE_STANDBY      = 3'd0;
   localparam logic [2:0] MODE_ISOLATED     = 3'd1;
   localparam logic [2:0] MODE_BALANCING    = 3'd2;
   localparam logic [2:0] MODE_SLAVE_CHARGE = 3'd3;

   localparam int FLAG_CONTACTOR = 0;
   localparam int FLAG_ALLOW_BAL = 1;

   // milliseconds per timeout unit
   localparam logic [15:0] TENTH_MS = 16'd100;

   typedef enum logic [3:0] {
      RSN_NONE        = 4'd0,
      RSN_STALE       = 4'd1,
      RSN_BAD_TIMEOUT = 4'd2,
      RSN_CURRENT     = 4'd3,
      RSN_FLAGS       = 4'd4,
      RSN_MODE        = 4'd5,
      RSN_FAULT       = 4'd6,
      RSN_MAINT       = 4'd7,
      RSN_SERVICE     = 4'd8,
      RSN_TIMEOUT     = 4'd9
   } reason_type;

   // request word, last declared field (now_ms) in the lowest bits
   typedef struct packed {
      logic [1:0]         pad;
      logic               service_lock;
      logic               maint_lock;
      logic               fault_active;
      logic [7:0]         sequence_req;
      logic [7:0]         timeout_tenths;
      logic [7:0]         flags;
      logic signed [15:0] discharge_setpoint;
      logic signed [15:0] charge_setpoint;
      logic [2:0]         mode;
      logic [31:0]        now_ms;
   } req_word_type;

   // response word, last declared field (event_flag) in the lowest bits
   typedef struct packed {
      logic [6:0]         pad;
      logic [7:0]         held_flags;
      logic signed [15:0] held_discharge;
      logic signed [15:0] held_charge;
      logic [2:0]         held_mode;
      logic [31:0]        expire_count;
      logic [31:0]        stale_count;
      logic [31:0]        reject_count;
      logic [31:0]        accept_count;
      logic [31:0]        age_ms;
      logic               is_fresh;
      logic [3:0]         reason;
      logic               event_flag;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] max_timeout_ms;
      logic [14:0] max_charge_limit;
      logic [14:0] max_discharge_limit;
      logic        bal_enable;
   } cfg_type;

   typedef struct packed {
      logic       seen;
      logic [7:0] prev_sequence;
   } seq_state_type;

   typedef struct packed {
      reason_type  reason;
      logic [15:0] timeout_ms;
   } check_type;

endpackage

>>> rtl/cvs_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvs_check
// Priority checks of one receive word against the configured limits and sequence state.
// ----------------------------------------------------------------------------
module cvs_check import cvs_pkg::*; (
   input  req_word_type  item,
   input  cfg_type       cfg,
   input  seq_state_type seq_state,
   output check_type     check
);

   logic [15:0]        tmo_ms;
   logic               contactor;
   logic               allow_bal;
   logic               chg_pos;
   logic               dis_pos;
   logic               energized;
   logic signed [15:0] chg_lim;
   logic signed [15:0] dis_lim;
   reason_type         reason;

   // at most 25500, never wraps 16 bits
   assign tmo_ms    = 16'(item.timeout_tenths) * TENTH_MS;
   assign contactor = item.flags[FLAG_CONTACTOR];
   assign allow_bal = item.flags[FLAG_ALLOW_BAL];
   assign chg_pos   = item.charge_setpoint > 16'sd0;
   assign dis_pos   = item.discharge_setpoint > 16'sd0;
   assign energized = contactor || chg_pos || dis_pos;
   assign chg_lim   = $signed({1'b0, cfg.max_charge_limit});
   assign dis_lim   = $signed({1'b0, cfg.max_discharge_limit});

   always_comb begin
      if (seq_state.seen && seq_state.prev_sequence == item.sequence_req) begin
         reason = RSN_STALE;
      end else if (tmo_ms == 16'd0 || tmo_ms > cfg.max_timeout_ms) begin
         reason = RSN_BAD_TIMEOUT;
      end else if (item.charge_setpoint < 16'sd0 || item.charge_setpoint > chg_lim ||
                   item.discharge_setpoint < 16'sd0 ||
                   item.discharge_setpoint > dis_lim) begin
         reason = RSN_CURRENT;
      end else if (chg_pos && dis_pos) begin
         reason = RSN_FLAGS;
      end else if (item.mode == MODE_BALANCING &&
                   (!allow_bal || !cfg.bal_enable)) begin
         reason = RSN_MODE;
      end else if (item.mode == MODE_ISOLATED && energized) begin
         reason = RSN_FLAGS;
      end else if (item.fault_active && energized) begin
         reason = RSN_FAULT;
      end else if (item.maint_lock && energized) begin
         reason = RSN_MAINT;
      end else if (item.service_lock && energized) begin
         reason = RSN_SERVICE;
      end else if (allow_bal && item.mode != MODE_BALANCING &&
                   item.mode != MODE_SLAVE_CHARGE && item.mode != MODE_STANDBY) begin
         reason = RSN_FLAGS;
      end else begin
         reason = RSN_NONE;
      end
   end

   assign check.reason     = reason;
   assign check.timeout_ms = tmo_ms;

endmodule

>>> rtl/cvs_super.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvs_super
// Held command, freshness supervision, counters and the response register.
// ----------------------------------------------------------------------------
module cvs_super import cvs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic          cmd,
   input  req_word_type  item,
   input  check_type     check,
   input  logic          rsp_tready,
   output logic          rsp_tvalid,
   output rsp_word_type  rsp_tdata,
   output seq_state_type seq_state
);

   logic               valid_ff, valid_in;
   logic               fresh_ff, fresh_in;
   logic [31:0]        rx_time_ff, rx_time_in;
   logic [15:0]        act_tmo_ff, act_tmo_in;
   logic [7:0]         prev_seq_ff, prev_seq_in;
   logic [2:0]         hold_mode_ff, hold_mode_in;
   logic signed [15:0] hold_chg_ff, hold_chg_in;
   logic signed [15:0] hold_dis_ff, hold_dis_in;
   logic [7:0]         hold_flags_ff, hold_flags_in;
   reason_type         reason_ff, reason_in;
   logic [31:0]        accept_cnt_ff, accept_cnt_in;
   logic [31:0]        reject_cnt_ff, reject_cnt_in;
   logic [31:0]        stale_cnt_ff, stale_cnt_in;
   logic [31:0]        expire_cnt_ff, expire_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;
   logic               event_flag;
   logic [31:0]        elapsed;

   assign elapsed = item.now_ms - rx_time_ff;

   always_comb begin
      valid_in      = valid_ff;
      fresh_in      = fresh_ff;
      rx_time_in    = rx_time_ff;
      act_tmo_in    = act_tmo_ff;
      prev_seq_in   = prev_seq_ff;
      hold_mode_in  = hold_mode_ff;
      hold_chg_in   = hold_chg_ff;
      hold_dis_in   = hold_dis_ff;
      hold_flags_in = hold_flags_ff;
      reason_in     = reason_ff;
      accept_cnt_in = accept_cnt_ff;
      reject_cnt_in = reject_cnt_ff;
      stale_cnt_in  = stale_cnt_ff;
      expire_cnt_in = expire_cnt_ff;
      event_flag    = 1'b0;
      if (cmd == CMD_RECEIVE) begin
         reason_in = check.reason;
         if (check.reason != RSN_NONE) begin
            reject_cnt_in = reject_cnt_ff + 32'd1;
            if (check.reason == RSN_STALE) begin
               stale_cnt_in = stale_cnt_ff + 32'd1;
            end
         end else begin
            valid_in      = 1'b1;
            fresh_in      = 1'b1;
            rx_time_in    = item.now_ms;
            act_tmo_in    = check.timeout_ms;
            prev_seq_in   = item.sequence_req;
            hold_mode_in  = item.mode;
            hold_chg_in   = item.charge_setpoint;
            hold_dis_in   = item.discharge_setpoint;
            hold_flags_in = item.flags;
            accept_cnt_in = accept_cnt_ff + 32'd1;
            event_flag    = 1'b1;
         end
      end else if (valid_ff && fresh_ff && elapsed > {16'd0, act_tmo_ff}) begin
         // expire once; further ticks see fresh low
         fresh_in      = 1'b0;
         expire_cnt_in = expire_cnt_ff + 32'd1;
         reason_in     = RSN_TIMEOUT;
         event_flag    = 1'b1;
      end
   end

   always_comb begin
      rsp_word_in.pad            = '0;
      rsp_word_in.event_flag     = event_flag;
      rsp_word_in.reason         = reason_in;
      rsp_word_in.is_fresh       = valid_in && fresh_in;
      rsp_word_in.age_ms         = valid_in ? (item.now_ms - rx_time_in) : '1;
      rsp_word_in.accept_count   = accept_cnt_in;
      rsp_word_in.reject_count   = reject_cnt_in;
      rsp_word_in.stale_count    = stale_cnt_in;
      rsp_word_in.expire_count   = expire_cnt_in;
      rsp_word_in.held_mode      = hold_mode_in;
      rsp_word_in.held_charge    = hold_chg_in;
      rsp_word_in.held_discharge = hold_dis_in;
      rsp_word_in.held_flags     = hold_flags_in;
   end

   // a word waiting in the response register drops once taken
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         fresh_ff      <= 1'b0;
         rx_time_ff    <= '0;
         act_tmo_ff    <= '0;
         prev_seq_ff   <= '0;
         hold_mode_ff  <= MODE_ISOLATED;
         hold_chg_ff   <= '0;
         hold_dis_ff   <= '0;
         hold_flags_ff <= '0;
         reason_ff     <= RSN_NONE;
         accept_cnt_ff <= '0;
         reject_cnt_ff <= '0;
         stale_cnt_ff  <= '0;
         expire_cnt_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            valid_ff      <= valid_in;
            fresh_ff      <= fresh_in;
            rx_time_ff    <= rx_time_in;
            act_tmo_ff    <= act_tmo_in;
            prev_seq_ff   <= prev_seq_in;
            hold_mode_ff  <= hold_mode_in;
            hold_chg_ff   <= hold_chg_in;
            hold_dis_ff   <= hold_dis_in;
            hold_flags_ff <= hold_flags_in;
            reason_ff     <= reason_in;
            accept_cnt_ff <= accept_cnt_in;
            reject_cnt_ff <= reject_cnt_in;
            stale_cnt_ff  <= stale_cnt_in;
            expire_cnt_ff <= expire_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_tvalid              = rsp_valid_ff;
   assign rsp_tdata               = rsp_word_ff;
   assign seq_state.seen          = valid_ff;
   assign seq_state.prev_sequence = prev_seq_ff;

   a_fresh_needs_valid: assert property (@(posedge clock) disable iff (reset)
      fresh_ff |-> valid_ff)
      else $error("fresh without a held command");

   a_accept_clears_reason: assert property (@(posedge clock) disable iff (reset)
      (accept_cnt_ff != $past(accept_cnt_ff)) |-> (reason_ff == RSN_NONE && fresh_ff))
      else $error("accepted command left a reason or no freshness");

   a_stale_is_reject: assert property (@(posedge clock) disable iff (reset)
      (stale_cnt_ff != $past(stale_cnt_ff)) |->
         (reject_cnt_ff != $past(reject_cnt_ff) && reason_ff == RSN_STALE))
      else $error("stale count moved without a stale rejection");

   a_expire_drops_fresh: assert property (@(posedge clock) disable iff (reset)
      (expire_cnt_ff != $past(expire_cnt_ff)) |->
         (!fresh_ff && reason_ff == RSN_TIMEOUT && $past(fresh_ff)))
      else $error("expiration without a fresh command");

   a_step_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("processed word did not reach the response register");

endmodule

>>> rtl/command_validate_supervise.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_validate_supervise
// Validates battery charge/discharge commands and supervises their freshness.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one word per handshake. req_tuser selects a receive (0) or a
//            time tick (1); on a tick only now_ms in req_tdata is used.
//   rsp_*  : exactly one response word per request word, in order, carrying
//            the event flag, last reason, freshness, age, the four counters
//            and the held command.
//   csr_*  : limit register writes (index 0..3); write only while idle.
//            csr_ready is always high, other indexes are ignored.
// A request handshake loads the request register, which feeds the checks and
// state update, whose result lands in the response register. Throughput is
// one word per cycle while the receiver takes every word, as the check/update
// in the supervisor is combinational. When the receiver
// stalls, the response register holds its word and the request register can
// still take one more word; req_tready drops only when both are full.
// Reset clears the held command (mode isolated), the counters, the limit
// registers and the valid flags of both pipeline registers.
// ----------------------------------------------------------------------------
module command_validate_supervise import cvs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // now_ms, mode, charge_setpoint, discharge_setpoint, flags,
   // timeout_tenths, sequence_req, fault_active, maint_lock, service_lock, pad
   input  logic [95:0]            req_tdata,
   input  logic                   req_tuser,  // cmd
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // event_flag, reason, is_fresh, age_ms, accept_count, reject_count,
   // stale_count, expire_count, held_mode, held_charge, held_discharge,
   // held_flags, pad
   output logic [215:0]           rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic          req_valid_ff, req_valid_in;
   logic          req_cmd_ff;
   req_word_type  req_word_ff;
   cfg_type       cfg_ff, cfg_in;
   logic          load_ok;
   logic          step;
   logic          req_accept;
   check_type     check;
   seq_state_type seq_state;
   rsp_word_type  rsp_word;

   assign load_ok      = !rsp_tvalid || rsp_tready;
   assign step         = req_valid_ff && load_ok;
   assign req_tready   = !req_valid_ff || load_ok;
   assign req_accept   = req_tvalid && req_tready;
   assign req_valid_in = req_accept || (req_valid_ff && !load_ok);
   assign csr_ready    = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MAX_TIMEOUT:   cfg_in.max_timeout_ms      = csr_data;
            CSR_MAX_CHARGE:    cfg_in.max_charge_limit    = csr_data[14:0];
            CSR_MAX_DISCHARGE: cfg_in.max_discharge_limit = csr_data[14:0];
            CSR_BAL_SUPPORTED: cfg_in.bal_enable          = csr_data[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         cfg_ff       <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_word_ff <= req_word_type'(req_tdata);
         req_cmd_ff  <= req_tuser;
      end
   end

   cvs_check u_check (
      .item      (req_word_ff),
      .cfg       (cfg_ff),
      .seq_state (seq_state),
      .check     (check)
   );

   cvs_super u_super (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .cmd        (req_cmd_ff),
      .item       (req_word_ff),
      .check      (check),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_word),
      .seq_state  (seq_state)
   );

   assign rsp_tdata = rsp_word;

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !load_ok) |=> (req_valid_ff && $stable(req_word_ff)))
      else $error("request register overwritten while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("response word changed while stalled");

   a_cfg_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(csr_valid) |-> $stable(cfg_ff))
      else $error("limit registers changed without a write");

endmodule

>>> test/tb_command_validate_supervise.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_command_validate_supervise
// Self-checking bench for the command validation and supervision block.
// Receive and tick words go in on the request stream, and the bench keeps its
// own copy of the supervisor state. Each response word is checked field by
// field against the status word predicted when its request was accepted.
// A short directed sequence covers each rejection reason, freshness expiry
// (including time wrap) and the limit extremes. Random traffic then runs under
// several limit settings, with sender bursts, receiver stalls and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb_command_validate_supervise;
   import cvs_pkg::*;

   localparam int     HALF_PERIOD   = 6;
   localparam int     RESET_CYCLES  = 9;
   localparam int     LONG_HOLD     = 150;
   localparam int     SETTLE_CYCLES = 8;
   localparam longint WATCHDOG_NS   = 64'd5_000_000;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 8'd77;

   localparam logic [7:0] CONTACTOR = 8'h01 << FLAG_CONTACTOR;
   localparam logic [7:0] ALLOW_BAL = 8'h01 << FLAG_ALLOW_BAL;
   localparam logic [7:0] SPARE_FLAG_BITS = 8'hFC;

   // lockout selectors for command_word: {service, maint, fault}
   localparam logic [2:0] LOCK_NONE    = 3'b000;
   localparam logic [2:0] LOCK_FAULT   = 3'b001;
   localparam logic [2:0] LOCK_MAINT   = 3'b010;
   localparam logic [2:0] LOCK_SERVICE = 3'b100;
   localparam logic [2:0] LOCK_ALL     = 3'b111;

   localparam logic [2:0] MODE_SPARE_5 = 3'd5;
   localparam logic [2:0] MODE_SPARE_7 = 3'd7;

   typedef enum int {LIMITS_FULL, LIMITS_RANDOM, LIMITS_TIGHT, LIMITS_ZERO} limit_profile_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [95:0]            req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [215:0]           rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   command_validate_supervise uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // supervisor copy kept by the bench
   cfg_type     limits         = '0;
   logic        cmd_valid      = 1'b0;
   logic        cmd_fresh      = 1'b0;
   logic        seq_seen       = 1'b0;
   logic [31:0] rx_time        = '0;
   logic [15:0] active_timeout = '0;
   logic [7:0]  prev_seq       = '0;
   logic [2:0]  held_mode      = MODE_ISOLATED;
   logic [15:0] held_charge    = '0;
   logic [15:0] held_discharge = '0;
   logic [7:0]  held_flags     = '0;
   reason_type  last_reason    = RSN_NONE;
   logic [31:0] accept_total   = '0;
   logic [31:0] reject_total   = '0;
   logic [31:0] stale_total    = '0;
   logic [31:0] expire_total   = '0;

   rsp_word_type pending_status[$];
   int           mismatch_count = 0;

   // stimulus state
   logic [31:0] clock_ms   = 32'd1000;
   logic [7:0]  gen_seq    = 8'd0;
   bit          pace_on    = 1'b1;
   int          burst_left = 0;

   // receiver control
   logic        stall_on      = 1'b0;
   int          hold_token    = 0;
   int          hold_seen     = 0;
   int          hold_left     = 0;
   logic [15:0] stall_pattern = 16'hA5B3;
   logic [3:0]  stall_step    = '0;

   function automatic reason_type judge_command(input req_word_type w,
                                                input logic [15:0] tmo);
      int   chg;
      int   dis;
      logic contactor;
      logic allow_bal;
      logic energized;
      chg = $signed(w.charge_setpoint);
      dis = $signed(w.discharge_setpoint);
      contactor = w.flags[FLAG_CONTACTOR];
      allow_bal = w.flags[FLAG_ALLOW_BAL];
      energized = contactor || chg > 0 || dis > 0;
      if (seq_seen && prev_seq == w.sequence_req) return RSN_STALE;
      if (tmo == 16'd0 || tmo > limits.max_timeout_ms) return RSN_BAD_TIMEOUT;
      if (chg < 0 || chg > int'(limits.max_charge_limit) ||
          dis < 0 || dis > int'(limits.max_discharge_limit)) return RSN_CURRENT;
      if (chg > 0 && dis > 0) return RSN_FLAGS;
      if (w.mode == MODE_BALANCING && (!allow_bal || !limits.bal_enable))
         return RSN_MODE;
      if (w.mode == MODE_ISOLATED && energized) return RSN_FLAGS;
      if (w.fault_active && energized) return RSN_FAULT;
      if (w.maint_lock && energized) return RSN_MAINT;
      if (w.service_lock && energized) return RSN_SERVICE;
      if (allow_bal && w.mode != MODE_BALANCING && w.mode != MODE_SLAVE_CHARGE &&
          w.mode != MODE_STANDBY) return RSN_FLAGS;
      return RSN_NONE;
   endfunction

   // advance the supervisor copy by one accepted word and queue its status
   task automatic supervise_step(input logic cmd, input req_word_type w);
      rsp_word_type s;
      logic [15:0]  tmo;
      reason_type   verdict;
      logic         fired;
      fired = 1'b0;
      if (cmd == CMD_RECEIVE) begin
         tmo = w.timeout_tenths * TENTH_MS;
         verdict = judge_command(w, tmo);
         last_reason = verdict;
         if (verdict != RSN_NONE) begin
            reject_total += 1;
            if (verdict == RSN_STALE) stale_total += 1;
         end else begin
            cmd_valid = 1'b1;
            cmd_fresh = 1'b1;
            seq_seen = 1'b1;
            rx_time = w.now_ms;
            active_timeout = tmo;
            prev_seq = w.sequence_req;
            held_mode = w.mode;
            held_charge = w.charge_setpoint;
            held_discharge = w.discharge_setpoint;
            held_flags = w.flags;
            accept_total += 1;
            fired = 1'b1;
         end
      end else if (cmd_valid && cmd_fresh &&
                   (w.now_ms - rx_time) > {16'd0, active_timeout}) begin
         cmd_fresh = 1'b0;
         expire_total += 1;
         last_reason = RSN_TIMEOUT;
         fired = 1'b1;
      end
      s = '0;
      s.event_flag = fired;
      s.reason = last_reason;
      s.is_fresh = cmd_valid && cmd_fresh;
      s.age_ms = cmd_valid ? w.now_ms - rx_time : 32'hFFFF_FFFF;
      s.accept_count = accept_total;
      s.reject_count = reject_total;
      s.stale_count = stale_total;
      s.expire_count = expire_total;
      s.held_mode = held_mode;
      s.held_charge = held_charge;
      s.held_discharge = held_discharge;
      s.held_flags = held_flags;
      pending_status.push_back(s);
   endtask

   task automatic send_item(input logic cmd, input req_word_type w);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= w;
      do @(posedge clock); while (req_tready !== 1'b1);
      supervise_step(cmd, w);
      if (pace_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(1, 9);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // keep csr_valid high across back-to-back writes; caller drops it
   task automatic put_register(input logic [CSR_INDEX_W-1:0] idx,
                               input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_MAX_TIMEOUT:   limits.max_timeout_ms = value;
         CSR_MAX_CHARGE:    limits.max_charge_limit = value[14:0];
         CSR_MAX_DISCHARGE: limits.max_discharge_limit = value[14:0];
         CSR_BAL_SUPPORTED: limits.bal_enable = value[0];
         default: ;
      endcase
   endtask

   task automatic load_limits(input cfg_type c, input bit with_stray);
      wait_idle();
      if (with_stray) put_register(CSR_UNMAPPED, 16'($urandom));
      put_register(CSR_MAX_TIMEOUT, c.max_timeout_ms);
      // junk in the unused upper bits must be dropped
      put_register(CSR_MAX_CHARGE, {1'($urandom), c.max_charge_limit});
      put_register(CSR_MAX_DISCHARGE, {1'($urandom), c.max_discharge_limit});
      put_register(CSR_BAL_SUPPORTED, {15'($urandom), c.bal_enable});
      csr_valid <= 1'b0;
   endtask

   function automatic req_word_type command_word(input logic [2:0] mode, input int chg,
                                                 input int dis, input logic [7:0] flags,
                                                 input logic [7:0] tenths,
                                                 input logic [7:0] seq,
                                                 input logic [2:0] locks,
                                                 input logic [31:0] now);
      req_word_type w;
      w = '0;
      w.now_ms = now;
      w.mode = mode;
      w.charge_setpoint = chg[15:0];
      w.discharge_setpoint = dis[15:0];
      w.flags = flags;
      w.timeout_tenths = tenths;
      w.sequence_req = seq;
      w.fault_active = locks[0];
      w.maint_lock = locks[1];
      w.service_lock = locks[2];
      return w;
   endfunction

   // a tick carries junk in every field but the time and the pad
   function automatic req_word_type tick_word(input logic [31:0] now);
      req_word_type w;
      w = req_word_type'({$urandom, $urandom, $urandom});
      w.pad = '0;
      w.now_ms = now;
      return w;
   endfunction

   task automatic random_item(output logic cmd, output req_word_type w);
      int          pick;
      int          side;
      int          max_tenths;
      logic [14:0] lim;
      w = req_word_type'({$urandom, $urandom, $urandom});
      w.pad = '0;
      if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
      else clock_ms += $urandom_range(0, 1 << $urandom_range(0, 15));
      w.now_ms = clock_ms;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         cmd = CMD_TICK;
         return;
      end
      cmd = CMD_RECEIVE;
      if (pick >= 92) return;
      // well-formed command with random content
      if ($urandom_range(0, 19) != 0) gen_seq += 8'd1;
      w.sequence_req = gen_seq;
      max_tenths = limits.max_timeout_ms / TENTH_MS;
      if (max_tenths > 255) max_tenths = 255;
      if (max_tenths == 0 || $urandom_range(0, 15) == 0) begin
         w.timeout_tenths = 8'($urandom_range(0, 255));
      end else begin
         w.timeout_tenths = 8'($urandom_range(1, max_tenths));
      end
      w.charge_setpoint = '0;
      w.discharge_setpoint = '0;
      side = $urandom_range(0, 9);
      if (side >= 3 && side != 6 && side != 7 && side != 8) begin
         lim = limits.max_charge_limit;
         w.charge_setpoint = ($urandom_range(0, 15) == 0) ? {1'b0, lim} + 16'd1 :
                                                            16'($urandom_range(0, lim));
      end
      if (side >= 6) begin
         lim = limits.max_discharge_limit;
         w.discharge_setpoint = ($urandom_range(0, 15) == 0) ? -16'sd1 :
                                                               16'($urandom_range(0, lim));
      end
      side = $urandom_range(0, 9);
      if (side < 3) w.mode = MODE_STANDBY;
      else if (side < 5) w.mode = MODE_SLAVE_CHARGE;
      else if (side < 7) w.mode = MODE_BALANCING;
      else w.mode = 3'($urandom_range(0, 7));
      w.flags = 8'($urandom_range(0, 255));
      if (w.mode == MODE_BALANCING) begin
         if ($urandom_range(0, 3) != 0) w.flags |= ALLOW_BAL;
      end else if ($urandom_range(0, 3) != 0) begin
         w.flags &= ~ALLOW_BAL;
      end
      w.fault_active = ($urandom_range(0, 7) == 0);
      w.maint_lock = ($urandom_range(0, 7) == 0);
      w.service_lock = ($urandom_range(0, 7) == 0);
   endtask

   task automatic test_power_up();
      send_item(CMD_TICK, tick_word(32'hFFFF_FFFF));
      send_item(CMD_RECEIVE, command_word(MODE_STANDBY, 0, 0, 8'h00, 8'd255, 8'd1,
                                          LOCK_NONE, 32'd0));
      load_limits('{16'hFFFF, 15'h7FFF, 15'h7FFF, 1'b1}, 1'b1);
      send_item(CMD_RECEIVE, command_word(MODE_STANDBY, 0, 0, 8'h00, 8'd0, 8'd1,
                                          LOCK_NONE, 32'd500));
   endtask

   task automatic test_priority_chain();
      send_item(CMD_RECEIVE, command_word(MODE_STANDBY, 32767, 0, 8'h00, 8'd255, 8'd10,
                                          LOCK_NONE, 32'd1000));
      send_item(CMD_RECEIVE, command_word(MODE_STANDBY, 0, 0, 8'h00, 8'd10, 8'd10,
                                          LOCK_NONE, 32'd1010));
      send_item(CMD_RECEIVE, command_word(MODE_STANDBY, -32768, 0, 8'h00, 8'd10, 8'd11,
                                          LOCK_NONE, 32'd1020));
      send_item(CMD_RECEIVE, command_word(MODE_SLAVE_CHARGE, 0, 32767, 8'h00, 8'd10, 8'd11,
                                          LOCK_NONE, 32'd1030));
      send_item(CMD_RECEIVE, command_word(MODE_STANDBY, 5, 5, 8'h00, 8'd10, 8'd12,
                                          LOCK_NONE, 32'd1040));
      send_item(CMD_RECEIVE, command_word(MODE_BALANCING, 0, 0, 8'h00, 8'd10, 8'd12,
                                          LOCK_NONE, 32'd1050));
      send_item(CMD_RECEIVE, command_word(MODE_BALANCING, 0, 0, ALLOW_BAL, 8'd10, 8'd12,
                                          LOCK_NONE, 32'd1060));
      send_item(CMD_RECEIVE, command_word(MODE_ISOLATED, 0, 0, CONTACTOR, 8'd10, 8'd13,
                                          LOCK_NONE, 32'd1070));
      send_item(CMD_RECEIVE, command_word(MODE_ISOLATED, 0, 0, SPARE_FLAG_BITS, 8'd10,
                                          8'd13, LOCK_NONE, 32'd1080));
      send_item(CMD_RECEIVE, command_word(MODE_STANDBY, 0, 0, CONTACTOR, 8'd10, 8'd14,
                                          LOCK_FAULT, 32'd1090));
      send_item(CMD_RECEIVE, command_word(MODE_STANDBY, 10, 0, 8'h00, 8'd10, 8'd14,
                                          LOCK_MAINT, 32'd1100));
      send_item(CMD_RECEIVE, command_word(MODE_STANDBY, 0, 10, 8'h00, 8'd10, 8'd14,
                                          LOCK_SERVICE, 32'd1110));
      send_item(CMD_RECEIVE, command_word(MODE_STANDBY, 0, 0, 8'h00, 8'd10, 8'd14,
                                          LOCK_ALL, 32'd1120));
      send_item(CMD_RECEIVE, command_word(MODE_SPARE_5, 0, 0, ALLOW_BAL, 8'd10, 8'd15,
                                          LOCK_NONE, 32'd1130));
      send_item(CMD_RECEIVE, command_word(MODE_SPARE_7, 100, 0, CONTACTOR, 8'd10, 8'd15,
                                          LOCK_NONE, 32'd1140));
   endtask

   task automatic test_freshness_expiry();
      send_item(CMD_RECEIVE, command_word(MODE_STANDBY, 0, 0, 8'h00, 8'd1, 8'd20,
                                          LOCK_NONE, 32'd50000));
      send_item(CMD_TICK, tick_word(32'd50100));
      send_item(CMD_TICK, tick_word(32'd50101));
      send_item(CMD_TICK, tick_word(32'd55000));
      // elapsed time must wrap through zero
      send_item(CMD_RECEIVE, command_word(MODE_STANDBY, 0, 0, 8'h00, 8'd2, 8'd21,
                                          LOCK_NONE, 32'hFFFF_FFA0));
      send_item(CMD_TICK, tick_word(32'h0000_0010));
      send_item(CMD_TICK, tick_word(32'h0000_0080));
   endtask

   task automatic test_zero_limits();
      load_limits('{16'd0, 15'd0, 15'd0, 1'b0}, 1'b0);
      send_item(CMD_RECEIVE, command_word(MODE_STANDBY, 0, 0, 8'h00, 8'd1, 8'd30,
                                          LOCK_NONE, 32'd60000));
      load_limits('{16'd100, 15'd0, 15'd1, 1'b0}, 1'b0);
      send_item(CMD_RECEIVE, command_word(MODE_STANDBY, 1, 0, 8'h00, 8'd1, 8'd30,
                                          LOCK_NONE, 32'd60010));
      send_item(CMD_RECEIVE, command_word(MODE_SLAVE_CHARGE, 0, 1, 8'h00, 8'd1, 8'd30,
                                          LOCK_NONE, 32'd60020));
      send_item(CMD_RECEIVE, command_word(MODE_BALANCING, 0, 0, ALLOW_BAL, 8'd1, 8'd31,
                                          LOCK_NONE, 32'd60030));
      send_item(CMD_RECEIVE, command_word(MODE_STANDBY, 0, 0, 8'h00, 8'd2, 8'd31,
                                          LOCK_NONE, 32'd60040));
   endtask

   task automatic test_random_traffic(input limit_profile_type profile, input int count);
      cfg_type      c;
      logic         cmd;
      req_word_type w;
      case (profile)
         LIMITS_FULL:   c = '{16'hFFFF, 15'h7FFF, 15'h7FFF, 1'b1};
         LIMITS_RANDOM: c = '{16'($urandom_range(100, 65535)),
                              15'($urandom_range(0, 32767)),
                              15'($urandom_range(0, 32767)), 1'($urandom)};
         LIMITS_TIGHT:  c = '{16'($urandom_range(1, 1000)), 15'($urandom_range(0, 40)),
                              15'($urandom_range(0, 40)), 1'($urandom)};
         default:       c = '0;
      endcase
      load_limits(c, 1'b1);
      for (int i = 0; i < count; i++) begin
         // reshuffle idling every hundred words, leaving some stretches clean
         if (i % 100 == 0) begin
            pace_on = ($urandom_range(0, 3) != 0);
            stall_on <= ($urandom_range(0, 3) != 0);
         end
         random_item(cmd, w);
         send_item(cmd, w);
      end
   endtask

   // hold the receiver off while words keep coming so the pipeline fills
   task automatic test_backpressure();
      logic         cmd;
      req_word_type w;
      wait_idle();
      pace_on = 1'b0;
      stall_on <= 1'b0;
      hold_token <= hold_token + 1;
      for (int i = 0; i < 100; i++) begin
         random_item(cmd, w);
         send_item(cmd, w);
      end
   endtask

   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_on) begin
         rsp_tready <= stall_pattern[0];
         stall_step <= stall_step + 4'd1;
         if (stall_step == 4'hF) stall_pattern <= 16'($urandom) | 16'h8001;
         else stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      rsp_word_type got;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got = rsp_word_type'(rsp_tdata);
         if (pending_status.size() == 0) begin
            $display("%0t: unexpected status word: expected none, actual %h", $time, got);
            mismatch_count++;
         end else begin
            want = pending_status.pop_front();
            compare_field("event_flag", 32'(want.event_flag), 32'(got.event_flag));
            compare_field("reason", 32'(want.reason), 32'(got.reason));
            compare_field("is_fresh", 32'(want.is_fresh), 32'(got.is_fresh));
            compare_field("age_ms", want.age_ms, got.age_ms);
            compare_field("accept_count", want.accept_count, got.accept_count);
            compare_field("reject_count", want.reject_count, got.reject_count);
            compare_field("stale_count", want.stale_count, got.stale_count);
            compare_field("expire_count", want.expire_count, got.expire_count);
            compare_field("held_mode", 32'(want.held_mode), 32'(got.held_mode));
            compare_field("held_charge", 32'(want.held_charge), 32'(got.held_charge));
            compare_field("held_discharge", 32'(want.held_discharge),
                          32'(got.held_discharge));
            compare_field("held_flags", 32'(want.held_flags), 32'(got.held_flags));
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_power_up();
      test_priority_chain();
      test_freshness_expiry();
      test_zero_limits();
      test_random_traffic(LIMITS_FULL, 450);
      test_random_traffic(LIMITS_RANDOM, 450);
      test_random_traffic(LIMITS_TIGHT, 400);
      test_random_traffic(LIMITS_ZERO, 100);
      test_random_traffic(LIMITS_RANDOM, 450);
      test_backpressure();
      test_random_traffic(LIMITS_TIGHT, 100);
      wait_idle();
      if (mismatch_count == 0 && pending_status.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #(WATCHDOG_NS);
      $display("TEST FAILED");
      $finish;
   end

endmodule
